FILE: rtl/core/galj_pkg.sv
// package for the gradient adaptive lattice joint-process estimator
// types, constants and saturation helpers; no dependencies
package galj_pkg;

    localparam int ORDER_DEFAULT = 16;
    localparam int DATA_W = 24;
    localparam int STATE_W = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] desired;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] forward_residual;
        logic signed [DATA_W-1:0] estimate_error;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_P_KD, ST_P_KF, ST_P_DF, ST_P_FR,
        ST_P_WR, ST_P_MK, ST_P_RE, ST_P_TE, ST_P_MW, ST_NEXT, ST_OUT
    } state_t;

    // saturate a 66-bit value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (x > hi) sat32 = 32'sh7fffffff;
        else if (x < lo) sat32 = 32'sh80000000;
        else sat32 = x[31:0];
    endfunction

    // clamp to +-2^38, result kept at 40 bits
    function automatic logic signed [39:0] satg(input logic signed [65:0] x);
        logic signed [65:0] lim;
        lim = 66'sd1 <<< 38;
        if (x > lim) satg = 40'sd1 <<< 38;
        else if (x < -lim) satg = -(40'sd1 <<< 38);
        else satg = x[39:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [31:0] x);
        if (x > 32'sd8388607) sat24 = 24'sh7fffff;
        else if (x < -32'sd8388608) sat24 = 24'sh800000;
        else sat24 = x[23:0];
    endfunction

    // round half up then arithmetic shift
    function automatic logic signed [65:0] rsh(input logic signed [65:0] x,
                                               input logic [4:0] s);
        logic signed [65:0] b;
        b = x + (66'sd1 <<< (s - 5'd1));
        rsh = b >>> s;
    endfunction

endpackage

FILE: rtl/core/galj_ram.sv
// generic simple dual-port ram (one write port, one read port) with registered read
// no dependencies
module galj_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/core/gradient_adaptive_lattice_joint.sv
// top level of the gradient adaptive lattice joint-process estimator
// depends on galj_pkg and galj_ram
//
// one beat in gives one beat out. each sample runs through ORDER lattice stages
// on one shared 32x40 multiplier; a stage is one memory read, nine multiply and
// update steps and one write back, and a new beat is accepted only once the
// previous sample has left its last step for the output register.
// the output register parts the two sides: s_ready is high whenever the core is
// idle, and a finished sample waits in its last step only while the previous
// result beat is still held. after reset the three state rams are zeroed by a
// clearing pass over all ORDER entries during which no beat is accepted.
// step_size may be written only while the core is idle.
module gradient_adaptive_lattice_joint #(
    parameter int ORDER = galj_pkg::ORDER_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [23:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  galj_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output galj_pkg::out_beat_t m_data
);
    localparam int AW = (ORDER > 1) ? $clog2(ORDER) : 1;

    galj_pkg::state_t state_reg, state_next;
    logic [AW-1:0] stage_reg, stage_next;
    logic [AW:0]   clr_reg;
    logic          clearing;
    logic [23:0]   mu_reg;

    // per-stage working values
    logic signed [31:0] f_reg, r_reg, e_reg, k_reg, d_reg, w_reg;
    logic signed [31:0] fn_reg, rn_reg;
    logic signed [41:0] g_reg;
    logic signed [65:0] prod_reg;
    logic signed [31:0] w_upd;

    logic               m_valid_reg;
    galj_pkg::out_beat_t m_data_reg;
    logic               out_load;

    // ram ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   k_wdata, d_wdata, w_wdata, k_rdata, d_rdata, w_rdata;

    // shared multiplier operands
    logic signed [31:0] mul_a;
    logic signed [39:0] mul_b;
    logic signed [65:0] mul_p;

    assign clearing = !clr_reg[AW];
    assign s_ready  = (state_reg == galj_pkg::ST_IDLE) && !clearing;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    // output register free or being emptied this cycle
    assign out_load = !m_valid_reg || m_ready;

    galj_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_k_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(k_wdata),
        .raddr(stage_reg), .rdata(k_rdata));
    galj_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_d_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(d_wdata),
        .raddr(stage_reg), .rdata(d_rdata));
    galj_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_w_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(w_wdata),
        .raddr(stage_reg), .rdata(w_rdata));

    // operand select for the one multiplier, product registered for the next step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            galj_pkg::ST_P_KD: begin
                mul_a = $signed(k_rdata);
                mul_b = 40'($signed(d_rdata));
            end
            galj_pkg::ST_P_KF: begin mul_a = k_reg; mul_b = 40'(f_reg);  end
            galj_pkg::ST_P_DF: begin mul_a = d_reg; mul_b = 40'(fn_reg); end
            galj_pkg::ST_P_FR: begin mul_a = f_reg; mul_b = 40'(rn_reg); end
            galj_pkg::ST_P_WR: begin mul_a = w_reg; mul_b = 40'(r_reg);  end
            galj_pkg::ST_P_MK: begin mul_a = $signed({8'd0, mu_reg}); mul_b = g_reg[39:0]; end
            galj_pkg::ST_P_RE: begin mul_a = r_reg; mul_b = 40'(e_reg);  end
            galj_pkg::ST_P_MW: begin mul_a = $signed({8'd0, mu_reg}); mul_b = g_reg[39:0]; end
            default: ;
        endcase
    end
    // gradients are held within +-2^38, so each gradient fits the 40-bit operand
    assign mul_p = 66'(mul_a * mul_b);

    // ladder weight update, written straight back to its ram
    assign w_upd = galj_pkg::sat32(66'(w_reg) + galj_pkg::rsh(prod_reg, 5'd22));

    // next state
    always_comb begin
        state_next = state_reg;
        stage_next = stage_reg;
        case (state_reg)
            galj_pkg::ST_IDLE: if (s_valid && s_ready) begin
                state_next = galj_pkg::ST_LOAD;
                stage_next = '0;
            end
            galj_pkg::ST_LOAD: state_next = galj_pkg::ST_P_KD;
            galj_pkg::ST_P_KD: state_next = galj_pkg::ST_P_KF;
            galj_pkg::ST_P_KF: state_next = galj_pkg::ST_P_DF;
            galj_pkg::ST_P_DF: state_next = galj_pkg::ST_P_FR;
            galj_pkg::ST_P_FR: state_next = galj_pkg::ST_P_WR;
            galj_pkg::ST_P_WR: state_next = galj_pkg::ST_P_MK;
            galj_pkg::ST_P_MK: state_next = galj_pkg::ST_P_RE;
            galj_pkg::ST_P_RE: state_next = galj_pkg::ST_P_TE;
            galj_pkg::ST_P_TE: state_next = galj_pkg::ST_P_MW;
            galj_pkg::ST_P_MW: state_next = galj_pkg::ST_NEXT;
            galj_pkg::ST_NEXT: begin
                if (32'(stage_reg) == ORDER - 1) begin
                    state_next = galj_pkg::ST_OUT;
                end else begin
                    state_next = galj_pkg::ST_LOAD;
                    stage_next = stage_reg + 1'b1;
                end
            end
            galj_pkg::ST_OUT: if (out_load) begin
                state_next = galj_pkg::ST_IDLE;
            end
            default: state_next = galj_pkg::ST_IDLE;
        endcase
    end

    // write back at the end of each stage, zeros during the clearing pass
    always_comb begin
        ram_we    = clearing || (state_reg == galj_pkg::ST_NEXT);
        ram_waddr = clearing ? clr_reg[AW-1:0] : stage_reg;
        k_wdata   = clearing ? '0 : k_reg;
        d_wdata   = clearing ? '0 : r_reg;
        w_wdata   = clearing ? '0 : w_upd;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= galj_pkg::ST_IDLE;
            stage_reg   <= '0;
            clr_reg     <= '0;
            mu_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            if (clearing) begin
                clr_reg <= (32'(clr_reg) == ORDER - 1) ? (AW+1)'(1 << AW)
                                                       : clr_reg + 1'b1;
            end
            if (cfg_we) mu_reg <= cfg_wdata;
            if (state_reg == galj_pkg::ST_OUT && out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        case (state_reg)
            galj_pkg::ST_IDLE: if (s_valid && s_ready) begin
                f_reg <= 32'(s_data.sample);
                r_reg <= 32'(s_data.sample);
                e_reg <= 32'(s_data.desired);
            end
            galj_pkg::ST_LOAD: ;
            galj_pkg::ST_P_KD: begin
                // ram data valid here
                k_reg <= k_rdata;
                d_reg <= d_rdata;
                w_reg <= w_rdata;
            end
            default: ;
        endcase
        // each step consumes the previous product
        case (state_reg)
            galj_pkg::ST_P_KF: fn_reg <= galj_pkg::sat32(66'(f_reg)
                                   + galj_pkg::rsh(prod_reg, 5'd30));
            galj_pkg::ST_P_DF: rn_reg <= galj_pkg::sat32(66'(d_reg)
                                   + galj_pkg::rsh(prod_reg, 5'd30));
            galj_pkg::ST_P_FR: g_reg <= 42'(galj_pkg::rsh(prod_reg, 5'd23));
            galj_pkg::ST_P_WR: g_reg <= 42'(galj_pkg::satg(66'(g_reg)
                                   + galj_pkg::rsh(prod_reg, 5'd23)));
            galj_pkg::ST_P_MK: e_reg <= galj_pkg::sat32(66'(e_reg)
                                   - galj_pkg::rsh(prod_reg, 5'd24));
            galj_pkg::ST_P_RE: k_reg <= galj_pkg::sat32(66'(k_reg)
                                   - galj_pkg::rsh(prod_reg, 5'd17));
            galj_pkg::ST_P_TE: g_reg <= 42'(galj_pkg::satg(galj_pkg::rsh(prod_reg, 5'd23)));
            galj_pkg::ST_OUT: if (out_load) begin
                m_data_reg.forward_residual <= galj_pkg::sat24(fn_reg);
                m_data_reg.estimate_error   <= galj_pkg::sat24(e_reg);
            end
            default: ;
        endcase
        // advance errors once a stage is written
        if (state_reg == galj_pkg::ST_LOAD && stage_reg != '0) begin
            f_reg <= fn_reg;
            r_reg <= rn_reg;
        end
    end

    // a stalled result beat holds still
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result beat changed while stalled");
    // result appears right after the last stage
    a_out_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == galj_pkg::ST_OUT) |=> m_valid)
        else $error("result not presented");
    // no beat during the clearing pass
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready)
        else $error("ready during clear");
endmodule

FILE: verif/gradient_adaptive_lattice_joint_test.sv
// testbench for the gradient adaptive lattice joint-process estimator
// bit-accurate lattice predictor in a scoreboard class, random and directed beats
// depends on galj_pkg and the gradient_adaptive_lattice_joint rtl
module gradient_adaptive_lattice_joint_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSTAGE = galj_pkg::ORDER_DEFAULT;
    localparam int WDOG_LIMIT = 20000;
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;
    localparam longint GLIM = 64'sd1 <<< 38;

    // lattice predictor plus queue of expected result beats
    class lattice_scoreboard;
        longint refl[NSTAGE];
        longint bdel[NSTAGE];
        longint ladw[NSTAGE];
        longint mu;
        galj_pkg::out_beat_t pending[$];
        int errors;

        function void clear_state();
            for (int n = 0; n < NSTAGE; n++) begin
                refl[n] = 0;
                bdel[n] = 0;
                ladw[n] = 0;
            end
            mu = 0;
            pending.delete();
            errors = 0;
        endfunction

        // round half up, then arithmetic shift
        function longint rnd(longint x, int s);
            longint b;
            b = x + (64'sd1 <<< (s - 1));
            return b >>> s;
        endfunction

        function longint lim(longint x, longint lo, longint hi);
            return x < lo ? lo : (x > hi ? hi : x);
        endfunction

        function void note_input(galj_pkg::in_beat_t b);
            longint f, r, e, k, d, w, fn, rn, grad, t;
            galj_pkg::out_beat_t o;
            f = longint'(b.sample);
            r = f;
            e = longint'(b.desired);
            for (int n = 0; n < NSTAGE; n++) begin
                k = refl[n];
                d = bdel[n];
                w = ladw[n];
                fn = lim(f + rnd(k * d, 30), S32_LO, S32_HI);
                rn = lim(d + rnd(k * f, 30), S32_LO, S32_HI);
                grad = lim(rnd(d * fn, 23) + rnd(f * rn, 23), -GLIM, GLIM);
                refl[n] = lim(k - rnd(mu * grad, 17), S32_LO, S32_HI);
                bdel[n] = r;
                e = lim(e - rnd(w * r, 24), S32_LO, S32_HI);
                t = lim(rnd(r * e, 23), -GLIM, GLIM);
                ladw[n] = lim(w + rnd(mu * t, 22), S32_LO, S32_HI);
                f = fn;
                r = rn;
            end
            o.forward_residual = 24'(lim(f, -64'sd8388608, 64'sd8388607));
            o.estimate_error = 24'(lim(e, -64'sd8388608, 64'sd8388607));
            pending.push_back(o);
        endfunction

        function void check_output(galj_pkg::out_beat_t got);
            galj_pkg::out_beat_t x;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected: %h", got);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (got.forward_residual !== x.forward_residual) begin
                $error("forward_residual expected %0d actual %0d",
                       x.forward_residual, got.forward_residual);
                errors++;
            end
            if (got.estimate_error !== x.estimate_error) begin
                $error("estimate_error expected %0d actual %0d",
                       x.estimate_error, got.estimate_error);
                errors++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [23:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    galj_pkg::in_beat_t s_data;
    logic m_valid;
    logic m_ready;
    galj_pkg::out_beat_t m_data;

    lattice_scoreboard lat_sb;
    int src_idle_pct;     // chance in 100 that the sender holds back a cycle
    int sink_stall_pct;   // chance in 100 that the receiver stalls a cycle
    int quiet_cycles;     // watchdog: cycles without any accepted beat
    bit timed_out;

    gradient_adaptive_lattice_joint u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // result side: check accepted beats, randomize m_ready, run the watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (m_valid && m_ready) lat_sb.check_output(m_data);
            if ((m_valid && m_ready) || (s_valid && s_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (quiet_cycles >= WDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Regression FAIL");
            $finish;
        end
    end

    // offer one beat, hold it until the handshake, note it when accepted
    task automatic send_beat(input logic [23:0] smp, input logic [23:0] des);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data.sample <= smp;
        s_data.desired <= des;
        do @(posedge aclk); while (!s_ready);
        lat_sb.note_input(s_data);
    endtask

    // wait until every expected beat has come, then let the core go idle
    task automatic drain();
        s_valid <= 1'b0;
        while (lat_sb.pending.size() != 0) @(posedge aclk);
        repeat (10 * NSTAGE + 20) @(posedge aclk);
    endtask

    // config writes happen only while the core is idle
    task automatic write_step(input logic [23:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        lat_sb.mu = longint'(v);
    endtask

    // random sample: moderate audio-like levels half the time, otherwise uniform random or full scale
    function automatic logic [23:0] rand_sample();
        case ($urandom_range(3))
            0: return 24'($urandom());
            1: return ($urandom_range(1)) ? 24'h7fffff : 24'h800000;
            default: return 24'($signed($urandom_range(65535)) - 32768) <<< 6;
        endcase
    endfunction

    // random burst of beats under the current step size
    task automatic random_phase(input int count, input logic [23:0] mu_v);
        write_step(mu_v);
        for (int i = 0; i < count; i++) send_beat(rand_sample(), rand_sample());
        drain();
    endtask

    initial begin
        lat_sb = new();
        lat_sb.clear_state();
        timed_out = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        src_idle_pct = 6;
        sink_stall_pct = 79;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes with zero step, then max and minimum step
        send_beat(24'h7fffff, 24'h800000);
        send_beat(24'h800000, 24'h7fffff);
        send_beat(24'h000000, 24'h000000);
        send_beat(24'hffffff, 24'h000001);
        send_beat(24'h555555, 24'haaaaaa);
        drain();
        write_step(24'hffffff);
        // saturation of coefficients and outputs under the largest step
        for (int i = 0; i < 8; i++)
            send_beat(i[0] ? 24'h7fffff : 24'h800000, i[1] ? 24'h800000 : 24'h7fffff);
        send_beat(24'haaaaaa, 24'h555555);
        send_beat(24'h000000, 24'h000000);
        drain();
        write_step(24'h000001);
        for (int i = 0; i < 6; i++) send_beat(rand_sample(), rand_sample());
        drain();

        random_phase(190, 24'h010000);
        random_phase(190, 24'h000400);
        src_idle_pct = 79;
        sink_stall_pct = 6;
        random_phase(190, 24'h100000);
        random_phase(190, 24'($urandom()));
        src_idle_pct = 0;
        sink_stall_pct = 0;
        random_phase(190, 24'h000000);
        random_phase(180, 24'hffffff);

        if (lat_sb.errors == 0 && lat_sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
